[src/msp_pkg.sv]
`timescale 1ns / 1ps
// Package for the motor speed PID loop: register indexes, reset values,
// datapath widths, the per-motor state record and the sequencer types.
// Depends on nothing.
package msp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 3'd6;

    localparam logic [15:0] RST_GAIN_P = 16'd8192;
    localparam logic [15:0] RST_GAIN_I = 16'd410;
    localparam logic [15:0] RST_GAIN_D = 16'd1229;
    localparam logic [15:0] RST_INTEGRAL_LIMIT = 16'd400;
    localparam logic [8:0] RST_FILTER_ALPHA = 9'd77;
    localparam logic [9:0] RST_TICK_RATE = 10'd50;
    localparam logic [15:0] RST_DUTY_MAX = 16'd1023;

    localparam logic [8:0] ALPHA_FULL = 9'd256;

    // Shared multiplier: 52-bit signed by 17-bit signed.
    localparam int MUL_A_W = 52;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PID_W = 52;

    typedef struct packed {
        logic [31:0] prev_count;
        logic signed [31:0] speed_smooth;
        logic signed [31:0] error_integral;
        logic [31:0] prev_magnitude;
        logic sat_flag;
        logic signed [15:0] prev_target;
    } motor_state_t;

    localparam int STATE_W = $bits(motor_state_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DELTA,
        ST_FILT,
        ST_SMOOTH,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_DONE
    } msp_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DELTA,
        MUL_FILT,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef struct packed {
        logic rd_en;
        logic ld_state;
        logic ld_smooth;
        logic ld_err;
        logic acc_load;
        logic acc_add;
        logic ld_pid;
        logic commit;
        mul_sel_t mul_sel;
    } msp_ctrl_t;

endpackage

[src/msp_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[src/msp_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on msp_pkg for the operand widths.
module msp_mul (
    input  logic                                 aclk,
    input  logic signed [msp_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [msp_pkg::MUL_B_W-1:0]   op_b,
    output logic signed [msp_pkg::MUL_P_W-1:0]   prod
);
    import msp_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;
endmodule

[src/msp_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the motor speed PID loop: steps one tick through read,
// filter, PID products unless the tick coasts, and write-back. Depends on msp_pkg.
module msp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                in_range,
    input  logic                coast,
    input  logic                out_free,
    output logic                s_ready,
    output msp_pkg::msp_ctrl_t  ctrl
);
    import msp_pkg::*;

    msp_state_t state_reg;
    msp_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && in_range) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_DELTA;
            ST_DELTA:  state_next = ST_FILT;
            ST_FILT:   state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_ERR;
            ST_ERR: begin
                state_next = coast ? ST_DONE : ST_MUL_P;
            end
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        ctrl = '0;
        ctrl.mul_sel = MUL_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ctrl.rd_en = s_valid && in_range;
            end
            ST_READ:   ctrl.ld_state = 1'b1;
            ST_DELTA:  ctrl.mul_sel = MUL_DELTA;
            ST_FILT:   ctrl.mul_sel = MUL_FILT;
            ST_SMOOTH: ctrl.ld_smooth = 1'b1;
            ST_ERR:    ctrl.ld_err = 1'b1;
            ST_MUL_P:  ctrl.mul_sel = MUL_P;
            ST_MUL_I: begin
                ctrl.mul_sel = MUL_I;
                ctrl.acc_load = 1'b1;
            end
            ST_MUL_D: begin
                ctrl.mul_sel = MUL_D;
                ctrl.acc_add = 1'b1;
            end
            ST_SUM:    ctrl.ld_pid = 1'b1;
            ST_DONE:   ctrl.commit = out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end
endmodule

[src/motor_speed_pid_loop.sv]
`timescale 1ns / 1ps
// Top level of the motor speed PID loop: configuration registers, per-motor
// state memory and the filter and PID datapath. Depends on msp_pkg, msp_ram,
// msp_mul and msp_ctrl.
//
// One request is one control tick for one motor. The block handles one tick
// at a time and is ready again once the result has been handed to the
// output register; a coasting tick skips the three PID products, and a
// tick for a motor number of MOTORS or above is taken and dropped without a
// result. The steps follow from the read of the state memory, whose data
// arrives in the cycle after the address, and from the single shared
// multiplier, which serves the speed scaling, the filter and the three PID
// products in turn. The result waits in an output register, so the next
// request is taken while it is still pending. All motor state reads as zero
// after reset. Configuration writes take effect at once; the user must make
// them only while no tick is in progress, which the block does not enforce.
module motor_speed_pid_loop #(
    parameter int MOTORS = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [msp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_motor_select,
    input  logic signed [31:0]                 s_encoder_count,
    input  logic signed [15:0]                 s_target_speed,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_motor_out,
    output logic [15:0]                        m_duty,
    output logic                               m_drive_forward,
    output logic                               m_drive_reverse,
    output logic                               m_drive_update,
    output logic                               m_coast,
    output logic                               m_clipped,
    output logic signed [31:0]                 m_speed_filtered
);
    import msp_pkg::*;

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    logic [15:0] gain_p_reg;
    logic [15:0] gain_i_reg;
    logic [15:0] gain_d_reg;
    logic [15:0] integral_limit_reg;
    logic [8:0]  filter_alpha_reg;
    logic [9:0]  tick_rate_reg;
    logic [15:0] duty_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= RST_GAIN_P;
            gain_i_reg <= RST_GAIN_I;
            gain_d_reg <= RST_GAIN_D;
            integral_limit_reg <= RST_INTEGRAL_LIMIT;
            filter_alpha_reg <= RST_FILTER_ALPHA;
            tick_rate_reg <= RST_TICK_RATE;
            duty_max_reg <= RST_DUTY_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GAIN_P:         gain_p_reg <= cfg_wdata;
                REG_GAIN_I:         gain_i_reg <= cfg_wdata;
                REG_GAIN_D:         gain_d_reg <= cfg_wdata;
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata;
                REG_FILTER_ALPHA:   filter_alpha_reg <= cfg_wdata[8:0];
                REG_TICK_RATE:      tick_rate_reg <= cfg_wdata[9:0];
                REG_DUTY_MAX:       duty_max_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    msp_ctrl_t ctrl;
    logic      in_range;
    logic      tgt_zero;
    logic      out_free;
    logic      m_valid_reg;

    assign in_range = 32'(s_motor_select) < MOTORS;
    assign out_free = !m_valid_reg || m_ready;

    msp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .in_range (in_range),
        .coast    (tgt_zero),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctrl     (ctrl)
    );

    logic [1:0]        motor_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [31:0]       cnt_reg;
    logic signed [15:0] tgt_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            motor_reg <= s_motor_select;
            idx_reg <= IDX_W'(s_motor_select);
            cnt_reg <= s_encoder_count;
            tgt_reg <= s_target_speed;
        end
    end

    assign tgt_zero = tgt_reg == 16'sd0;

    logic [STATE_W-1:0] ram_rdata;
    logic [STATE_W-1:0] ram_wdata;
    logic [MOTORS-1:0]  valid_reg;
    motor_state_t       ent;
    motor_state_t       wr_ent;

    msp_ram #(
        .WIDTH  (STATE_W),
        .DEPTH  (MOTORS),
        .ADDR_W (IDX_W)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ctrl.commit),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ctrl.rd_en),
        .raddr (IDX_W'(s_motor_select)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.commit) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    assign ent = valid_reg[idx_reg] ? motor_state_t'(ram_rdata) : '0;

    // Target handling and the old state of the motor.
    logic clr;
    logic signed [31:0] delta_reg;
    logic signed [31:0] smooth_old_reg;
    logic signed [31:0] integ_old_reg;
    logic [31:0]        pmag_old_reg;
    logic               sat_old_reg;

    assign clr = tgt_zero || ((tgt_reg > 16'sd0) != (ent.prev_target > 16'sd0));

    always_ff @(posedge aclk) begin
        if (ctrl.ld_state) begin
            delta_reg <= signed'(cnt_reg - ent.prev_count);
            smooth_old_reg <= ent.speed_smooth;
            integ_old_reg <= clr ? 32'sd0 : ent.error_integral;
            pmag_old_reg <= clr ? 32'd0 : ent.prev_magnitude;
            sat_old_reg <= ent.sat_flag;
        end
    end

    // Shared multiplier and its operand selection.
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [MUL_A_W-1:0] raw;
    logic signed [MUL_A_W-1:0] diff;
    logic [8:0]                alpha;
    logic signed [32:0]        err_reg;
    logic signed [31:0]        integ_reg;
    logic signed [32:0]        d_reg;

    assign raw = signed'({prod[43:0], 8'h00});
    assign diff = raw - MUL_A_W'(smooth_old_reg);
    assign alpha = (filter_alpha_reg > ALPHA_FULL) ? ALPHA_FULL : filter_alpha_reg;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.mul_sel)
            MUL_DELTA: begin
                op_a = MUL_A_W'(delta_reg);
                op_b = signed'({7'd0, tick_rate_reg});
            end
            MUL_FILT: begin
                op_a = diff;
                op_b = signed'({8'd0, alpha});
            end
            MUL_P: begin
                op_a = MUL_A_W'(err_reg);
                op_b = signed'({1'b0, gain_p_reg});
            end
            MUL_I: begin
                op_a = MUL_A_W'(integ_reg);
                op_b = signed'({1'b0, gain_i_reg});
            end
            MUL_D: begin
                op_a = MUL_A_W'(d_reg);
                op_b = signed'({1'b0, gain_d_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    msp_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Filter update with saturation to 32 bits.
    logic signed [MUL_P_W-1:0] step;
    logic signed [53:0]        smooth_sum;
    logic signed [31:0]        smooth_sat;
    logic signed [31:0]        smooth_reg;

    assign step = prod >>> 8;
    assign smooth_sum = 54'(smooth_old_reg) + signed'(step[53:0]);

    always_comb begin
        if (!smooth_sum[53] && (smooth_sum[52:31] != '0)) begin
            smooth_sat = 32'sh7FFF_FFFF;
        end else if (smooth_sum[53] && (smooth_sum[52:31] != '1)) begin
            smooth_sat = 32'sh8000_0000;
        end else begin
            smooth_sat = smooth_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_smooth) begin
            smooth_reg <= smooth_sat;
        end
    end

    // Error, clamped integral and derivative on the magnitudes.
    logic [31:0]        mag;
    logic [15:0]        tgt_abs;
    logic signed [32:0] err_n;
    logic signed [33:0] isum;
    logic signed [33:0] lim;
    logic signed [31:0] integ_n;
    logic [31:0]        mag_reg;

    assign mag = smooth_reg[31] ? (~smooth_reg + 32'd1) : smooth_reg;
    assign tgt_abs = tgt_reg[15] ? (~tgt_reg + 16'd1) : tgt_reg;
    assign err_n = signed'(33'({tgt_abs, 8'h00})) - signed'({1'b0, mag});
    assign isum = 34'(integ_old_reg) + 34'(err_n);
    assign lim = signed'(34'({integral_limit_reg, 8'h00}));

    always_comb begin
        if (sat_old_reg) begin
            integ_n = integ_old_reg;
        end else if (isum > lim) begin
            integ_n = lim[31:0];
        end else if (isum < -lim) begin
            integ_n = 32'(-lim);
        end else begin
            integ_n = isum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_err) begin
            err_reg <= err_n;
            integ_reg <= integ_n;
            d_reg <= signed'({1'b0, pmag_old_reg}) - signed'({1'b0, mag});
            mag_reg <= mag;
        end
    end

    // Sum of the three products.
    logic signed [PID_W-1:0] acc_reg;
    logic signed [PID_W-1:0] pid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.acc_load) begin
            acc_reg <= prod[PID_W-1:0];
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + prod[PID_W-1:0];
        end
        if (ctrl.ld_pid) begin
            pid_reg <= acc_reg + prod[PID_W-1:0];
        end
    end

    // Duty limiting.
    logic signed [PID_W-1:0] top;
    logic                    clip;
    logic [15:0]             duty_n;

    assign top = signed'(PID_W'({duty_max_reg, 20'd0}));

    always_comb begin
        if (pid_reg[PID_W-1]) begin
            duty_n = 16'd0;
            clip = 1'b1;
        end else if (pid_reg > top) begin
            duty_n = duty_max_reg;
            clip = 1'b1;
        end else begin
            duty_n = pid_reg[35:20];
            clip = 1'b0;
        end
    end

    always_comb begin
        wr_ent.prev_count = cnt_reg;
        wr_ent.speed_smooth = smooth_reg;
        wr_ent.error_integral = tgt_zero ? integ_old_reg : integ_reg;
        wr_ent.prev_magnitude = tgt_zero ? pmag_old_reg : mag_reg;
        wr_ent.sat_flag = tgt_zero ? sat_old_reg : clip;
        wr_ent.prev_target = tgt_reg;
    end

    assign ram_wdata = wr_ent;

    // Output register.
    logic [1:0]         motor_out_reg;
    logic [15:0]        duty_reg;
    logic               fwd_reg;
    logic               rev_reg;
    logic               update_reg;
    logic               coast_reg;
    logic               clipped_reg;
    logic signed [31:0] speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            motor_out_reg <= motor_reg;
            speed_reg <= smooth_reg;
            coast_reg <= tgt_zero;
            duty_reg <= tgt_zero ? 16'd0 : duty_n;
            fwd_reg <= !tgt_zero && !tgt_reg[15];
            rev_reg <= tgt_reg[15];
            update_reg <= !tgt_zero;
            clipped_reg <= !tgt_zero && clip;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_motor_out = motor_out_reg;
    assign m_duty = duty_reg;
    assign m_drive_forward = fwd_reg;
    assign m_drive_reverse = rev_reg;
    assign m_drive_update = update_reg;
    assign m_coast = coast_reg;
    assign m_clipped = clipped_reg;
    assign m_speed_filtered = speed_reg;

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> m_valid)
        else $error("Committed tick did not produce a result.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!m_valid || m_ready))
        else $error("Result overwritten while still pending.");

    a_drop_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !in_range) |=> s_ready)
        else $error("Request for a missing motor started a tick.");

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.rd_en, ctrl.ld_state, ctrl.ld_smooth, ctrl.ld_err, ctrl.commit}))
        else $error("More than one sequencer step active.");

endmodule
